FILE: src/dmws_pkg.sv
// Shared types, codes and constants of the motif weight matrix scanner.
// No dependencies; dmws_ctrl, dmws_dp and the top level import it.
`timescale 1ns / 1ps
package dmws_pkg;

    localparam int MAX_MATRICES_DEF = 4;
    localparam int MAX_SPAN_DEF     = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int SCORE_W   = 22;
    localparam int SCORE_MAX = 2097151;
    localparam int SCORE_MIN = -2097152;
    localparam int CFG_W     = 22;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CH_HEADER  = 8'h3E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [2:0] CODE_OTHER = 3'd4;

    typedef enum logic [1:0] {
        REQ_FWD  = 2'd0,
        REQ_REV  = 2'd1,
        REQ_BG   = 2'd2,
        REQ_BYTE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_MATS   = 2'd1,
        CFG_SPAN   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_SEQ    = 2'd2
    } parse_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT_F,
        ST_EMIT_R
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic out_rev;
        logic out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic window_go;
        logic issue_last;
        logic done;
        logic fwd_hit;
        logic rev_hit;
    } dp_status_t;

    function automatic logic [2:0] base_of(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            8'h41, 8'h61: code = 3'd0;
            8'h43, 8'h63: code = 3'd1;
            8'h47, 8'h67: code = 3'd2;
            8'h54, 8'h74: code = 3'd3;
            default:      code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

FILE: src/dmws_req_if.sv
// Request and result channels of the scanner: valid/ready plus payload.
// Depends on nothing but the package widths being fixed here.
`timescale 1ns / 1ps
interface dmws_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  matrix_index;
    logic [3:0]  column;
    logic [1:0]  base_code;
    logic signed [15:0] weight_value;
    logic [7:0]  seq_byte;

    modport source (output valid, req_type, matrix_index, column, base_code,
                    weight_value, seq_byte, input ready);
    modport sink   (input valid, req_type, matrix_index, column, base_code,
                    weight_value, seq_byte, output ready);
endinterface

interface dmws_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] record_index;
    logic [31:0] position;
    logic        strand;
    logic [1:0]  best_matrix;
    logic signed [21:0] best_score;
    logic [31:0] window_bases;
    logic        last;

    modport source (output valid, record_index, position, strand, best_matrix,
                    best_score, window_bases, last, input ready);
    modport sink   (input valid, record_index, position, strand, best_matrix,
                    best_score, window_bases, last, output ready);
endinterface

FILE: src/dmws_ctrl.sv
// Scanner sequencer: accept, scan, drain and result delivery states.
// Depends on dmws_pkg.
`timescale 1ns / 1ps
module dmws_ctrl
    import dmws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       res_ready,
    input  dp_status_t sts,
    output logic       req_ready,
    output logic       res_valid,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && sts.window_go)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.issue_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    if (sts.fwd_hit)
                    begin
                        state_next = ST_EMIT_F;
                    end
                    else if (sts.rev_hit)
                    begin
                        state_next = ST_EMIT_R;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_F:
            begin
                if (res_ready)
                begin
                    state_next = sts.rev_hit ? ST_EMIT_R : ST_IDLE;
                end
            end
            ST_EMIT_R:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        res_valid    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_WAIT:
            begin
            end
            ST_EMIT_F:
            begin
                res_valid    = 1'b1;
                cmd.out_last = !sts.rev_hit;
            end
            ST_EMIT_R:
            begin
                res_valid    = 1'b1;
                cmd.out_rev  = 1'b1;
                cmd.out_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: src/dmws_dp.sv
// Scanner datapath: weight memories, FASTA parser, base window, score
// accumulators and best-matrix tracking. Depends on dmws_pkg.
`timescale 1ns / 1ps
module dmws_dp
    import dmws_pkg::*;
#(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int MAX_SPAN     = MAX_SPAN_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    input  logic [1:0]         req_type,
    input  logic [1:0]         matrix_index,
    input  logic [3:0]         column,
    input  logic [1:0]         base_code,
    input  logic signed [15:0] weight_value,
    input  logic [7:0]         seq_byte,
    input  logic signed [SCORE_W-1:0] cutoff,
    input  logic [2:0]         mats_cfg,
    input  logic [4:0]         span_cfg,
    output dp_status_t         sts,
    output logic [15:0]        record_index,
    output logic [31:0]        position,
    output logic               strand,
    output logic [1:0]         best_matrix,
    output logic signed [SCORE_W-1:0] best_score,
    output logic [31:0]        window_bases,
    output logic               last
);

    localparam int DEPTH   = MAX_MATRICES * MAX_SPAN * 4;
    localparam int AW      = $clog2(DEPTH);
    localparam int MW      = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int CW      = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int SPW     = $clog2(MAX_SPAN + 1);
    localparam int MCW     = $clog2(MAX_MATRICES + 1);
    localparam int ACC_RAW = WEIGHT_BITS + 2 + $clog2(MAX_SPAN + 1);
    localparam int ACC_W   = (ACC_RAW > SCORE_W + 1) ? ACC_RAW : SCORE_W + 1;
    localparam int OUT_BASES = (MAX_SPAN < 16) ? MAX_SPAN : 16;

    logic signed [WEIGHT_BITS-1:0] fwd_mem [DEPTH];
    logic signed [WEIGHT_BITS-1:0] rev_mem [DEPTH];
    logic signed [WEIGHT_BITS-1:0] bg_mem  [4];
    logic signed [WEIGHT_BITS-1:0] fwd_q, rev_q, bg_q;

    logic [2:0]        win_reg [MAX_SPAN];
    parse_mode_t       mode_reg;
    logic [31:0]       bir_reg;
    logic [15:0]       rc_reg;

    logic [MW-1:0]     m_reg;
    logic [CW-1:0]     c_reg;

    logic              rd_valid_reg, rd_first_reg, rd_lastc_reg, rd_lastm_reg, rd_ok_reg;
    logic              rd_firstm_reg;
    logic [MW-1:0]     rd_m_reg;
    logic signed [ACC_W-1:0] acc_f_reg, acc_r_reg, fin_f_reg, fin_r_reg;
    logic              fin_valid_reg, fin_lastm_reg, fin_firstm_reg;
    logic [MW-1:0]     fin_m_reg;
    logic signed [SCORE_W-1:0] best_f_reg, best_r_reg;
    logic [MW-1:0]     idx_f_reg, idx_r_reg;
    logic              done_reg;

    logic [SPW-1:0]    span_eff;
    logic [MCW-1:0]    mats_eff;
    logic [WEIGHT_BITS-1:0] w_load;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              wr_ok;
    logic              is_byte, is_base;
    logic [31:0]       bir_inc;
    logic [2:0]        cur_code;
    logic [CW-1:0]     sel_idx;
    logic              last_c, last_m;
    logic signed [ACC_W-1:0] term_f, term_r, sum_f, sum_r;
    logic signed [SCORE_W-1:0] cl_f, cl_r;

    // Saturate the configured counts into their legal ranges.
    always_comb
    begin
        if (span_cfg == 5'd0)
        begin
            span_eff = SPW'(1);
        end
        else if (int'(span_cfg) > MAX_SPAN)
        begin
            span_eff = SPW'(MAX_SPAN);
        end
        else
        begin
            span_eff = SPW'(span_cfg);
        end
        if (mats_cfg == 3'd0)
        begin
            mats_eff = MCW'(1);
        end
        else if (int'(mats_cfg) > MAX_MATRICES)
        begin
            mats_eff = MCW'(MAX_MATRICES);
        end
        else
        begin
            mats_eff = MCW'(mats_cfg);
        end
    end

    // Weight loads.
    assign w_load  = WEIGHT_BITS'(32'(weight_value));
    assign wr_ok   = (int'(matrix_index) < MAX_MATRICES) && (int'(column) < MAX_SPAN);
    assign wr_addr = AW'((int'(matrix_index) * MAX_SPAN + int'(column)) * 4
                         + int'(base_code));

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_ok && req_type == REQ_FWD)
        begin
            fwd_mem[wr_addr] <= w_load;
        end
        if (cmd.accept && wr_ok && req_type == REQ_REV)
        begin
            rev_mem[wr_addr] <= w_load;
        end
        if (cmd.accept && req_type == REQ_BG)
        begin
            bg_mem[base_code] <= w_load;
        end
        fwd_q <= fwd_mem[rd_addr];
        rev_q <= rev_mem[rd_addr];
        bg_q  <= bg_mem[cur_code[1:0]];
    end

    // FASTA parse.
    assign is_byte = cmd.accept && req_type == REQ_BYTE;
    assign is_base = is_byte && mode_reg == MODE_SEQ && seq_byte != CH_HEADER
                     && seq_byte != CH_NEWLINE;
    assign bir_inc = (bir_reg == 32'hFFFF_FFFF) ? bir_reg : bir_reg + 32'd1;
    assign sts.window_go = is_base && bir_inc >= 32'(span_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAIT;
            bir_reg  <= '0;
            rc_reg   <= '0;
            for (int i = 0; i < MAX_SPAN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (is_byte)
        begin
            if (mode_reg == MODE_HEADER)
            begin
                if (seq_byte == CH_NEWLINE)
                begin
                    mode_reg <= MODE_SEQ;
                    bir_reg  <= '0;
                end
            end
            else if (seq_byte == CH_HEADER)
            begin
                mode_reg <= MODE_HEADER;
                rc_reg   <= rc_reg + 16'd1;
            end
            else if (is_base)
            begin
                for (int i = 0; i < MAX_SPAN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[MAX_SPAN - 1] <= base_of(seq_byte);
                bir_reg <= bir_inc;
            end
        end
    end

    // Scan counters: one matrix column per cycle.
    assign sel_idx  = CW'(MAX_SPAN - int'(span_eff) + int'(c_reg));
    assign cur_code = win_reg[sel_idx];
    assign rd_addr  = AW'((int'(m_reg) * MAX_SPAN + int'(c_reg)) * 4
                          + int'(cur_code[1:0]));
    assign last_c   = int'(c_reg) == int'(span_eff) - 1;
    assign last_m   = int'(m_reg) == int'(mats_eff) - 1;
    assign sts.issue_last = last_c && last_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg         <= '0;
            c_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                m_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.scan)
            begin
                if (last_c)
                begin
                    c_reg <= '0;
                    m_reg <= m_reg + MW'(1);
                end
                else
                begin
                    c_reg <= c_reg + CW'(1);
                end
            end
            rd_valid_reg  <= cmd.scan;
            fin_valid_reg <= rd_valid_reg && rd_lastc_reg;
            done_reg      <= fin_valid_reg && fin_lastm_reg;
        end
    end

    // Read stage tags, then accumulate weight minus background.
    assign term_f = rd_ok_reg ? ACC_W'(fwd_q) - ACC_W'(bg_q) : '0;
    assign term_r = rd_ok_reg ? ACC_W'(rev_q) - ACC_W'(bg_q) : '0;
    assign sum_f  = (rd_first_reg ? '0 : acc_f_reg) + term_f;
    assign sum_r  = (rd_first_reg ? '0 : acc_r_reg) + term_r;

    always_ff @(posedge clk)
    begin
        rd_first_reg  <= c_reg == '0;
        rd_lastc_reg  <= last_c;
        rd_lastm_reg  <= last_m;
        rd_firstm_reg <= m_reg == '0;
        rd_ok_reg     <= cur_code != CODE_OTHER;
        rd_m_reg      <= m_reg;
        if (rd_valid_reg)
        begin
            acc_f_reg <= sum_f;
            acc_r_reg <= sum_r;
        end
        if (rd_valid_reg && rd_lastc_reg)
        begin
            fin_f_reg      <= sum_f;
            fin_r_reg      <= sum_r;
            fin_m_reg      <= rd_m_reg;
            fin_lastm_reg  <= rd_lastm_reg;
            fin_firstm_reg <= rd_firstm_reg;
        end
    end

    // Saturate and keep the strict maximum; lowest index holds ties.
    always_comb
    begin
        if (fin_f_reg > ACC_W'(SCORE_MAX))
        begin
            cl_f = SCORE_W'(SCORE_MAX);
        end
        else if (fin_f_reg < ACC_W'(SCORE_MIN))
        begin
            cl_f = SCORE_W'(SCORE_MIN);
        end
        else
        begin
            cl_f = fin_f_reg[SCORE_W-1:0];
        end
        if (fin_r_reg > ACC_W'(SCORE_MAX))
        begin
            cl_r = SCORE_W'(SCORE_MAX);
        end
        else if (fin_r_reg < ACC_W'(SCORE_MIN))
        begin
            cl_r = SCORE_W'(SCORE_MIN);
        end
        else
        begin
            cl_r = fin_r_reg[SCORE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid_reg)
        begin
            if (fin_firstm_reg || cl_f > best_f_reg)
            begin
                best_f_reg <= cl_f;
                idx_f_reg  <= fin_m_reg;
            end
            if (fin_firstm_reg || cl_r > best_r_reg)
            begin
                best_r_reg <= cl_r;
                idx_r_reg  <= fin_m_reg;
            end
        end
    end

    assign sts.done    = done_reg;
    assign sts.fwd_hit = best_f_reg > cutoff;
    assign sts.rev_hit = best_r_reg > cutoff;

    // Result payload, built from the held window and best registers.
    always_comb
    begin
        logic [31:0] fb, rb;
        int          fi, ri;
        fb = '0;
        rb = '0;
        for (int c = 0; c < OUT_BASES; c++)
        begin
            fi = MAX_SPAN - int'(span_eff) + c;
            ri = MAX_SPAN - 1 - c;
            if (c < int'(span_eff))
            begin
                fb[2*c +: 2] = (win_reg[CW'(fi)] == CODE_OTHER) ? 2'd0
                               : win_reg[CW'(fi)][1:0];
                rb[2*c +: 2] = (win_reg[CW'(ri)] == CODE_OTHER) ? 2'd0
                               : 2'd3 - win_reg[CW'(ri)][1:0];
            end
        end
        window_bases = cmd.out_rev ? rb : fb;
    end

    assign record_index = rc_reg;
    assign position     = (bir_reg == 32'hFFFF_FFFF) ? bir_reg
                          : bir_reg - 32'(span_eff) + 32'd1;
    assign strand       = cmd.out_rev;
    assign best_matrix  = 2'(cmd.out_rev ? idx_r_reg : idx_f_reg);
    assign best_score   = cmd.out_rev ? best_r_reg : best_f_reg;
    assign last         = cmd.out_last;

endmodule

FILE: src/dna_motif_weight_matrix_scanner_top.sv
// Top level of the motif weight matrix scanner: configuration registers,
// sequencer and datapath. Depends on dmws_pkg, dmws_req_if, dmws_ctrl, dmws_dp.
`timescale 1ns / 1ps
// A load or non-scoring byte is taken in the idle state. A base that completes a
// window is scanned over all matrices, then each hit is delivered as a result
// (at most 2, forward first). The scan loop reads one weight column a cycle
// from the single read port of each weight memory, which sets the rate.
// Reset (rst_n, async low) clears parser, window, counters and configuration
// registers to defaults; weight memories hold no reset contents.
module dna_motif_weight_matrix_scanner_top
    import dmws_pkg::*;
#(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int MAX_SPAN     = MAX_SPAN_DEF,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dmws_req_if.sink             req_ch,
    dmws_res_if.source           res_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // Configuration registers, to be written only while the block is idle; the block does not enforce this.
    logic signed [SCORE_W-1:0] cutoff_reg;
    logic [2:0]                mats_reg;
    logic [4:0]                span_reg;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
            mats_reg   <= 3'd1;
            span_reg   <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CUTOFF: cutoff_reg <= cfg_wdata;
                CFG_MATS:   mats_reg   <= cfg_wdata[2:0];
                CFG_SPAN:   span_reg   <= cfg_wdata[4:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: takes one transaction at a time, holds the result until taken.
    dmws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .res_ready (res_ch.ready),
        .sts       (sts),
        .req_ready (req_ch.ready),
        .res_valid (res_ch.valid),
        .cmd       (cmd)
    );

    // Datapath: parse, scan the window over all matrices, track the best.
    dmws_dp #(
        .MAX_MATRICES (MAX_MATRICES),
        .MAX_SPAN     (MAX_SPAN),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_ch.req_type),
        .matrix_index (req_ch.matrix_index),
        .column       (req_ch.column),
        .base_code    (req_ch.base_code),
        .weight_value (req_ch.weight_value),
        .seq_byte     (req_ch.seq_byte),
        .cutoff       (cutoff_reg),
        .mats_cfg     (mats_reg),
        .span_cfg     (span_reg),
        .sts          (sts),
        .record_index (res_ch.record_index),
        .position     (res_ch.position),
        .strand       (res_ch.strand),
        .best_matrix  (res_ch.best_matrix),
        .best_score   (res_ch.best_score),
        .window_bases (res_ch.window_bases),
        .last         (res_ch.last)
    );

    // No new request is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid |-> !req_ch.ready)
        else $error("request accepted while result pending");

    // The reverse-strand result always closes the transaction's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.strand |-> res_ch.last)
        else $error("reverse result without last");

    // A forward result not marked last is followed by the reverse result.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.ready && !res_ch.last |=> res_ch.valid && res_ch.strand)
        else $error("missing reverse result after forward");

    // No scan column is issued while the final results are signalled as done.
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> !cmd.scan)
        else $error("scan still issuing when results are final");

endmodule
